FILE: rtl/pert_pkg.sv
// ----------------------------------------------------------------------------
// pert_pkg
// Shared types and constants of the per-process event rule table.
// ----------------------------------------------------------------------------
package pert_pkg;

  localparam int PID_W  = 32;
  localparam int TS_W   = 64;
  localparam int IP_W   = 32;
  localparam int FUNC_W = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // in_tdata: pid, timestamp, sensitive_path, dest_ip, zero fill to bytes
  localparam int IN_PID_LSB  = 0;
  localparam int IN_TS_LSB   = IN_PID_LSB + PID_W;
  localparam int IN_SENS_BIT = IN_TS_LSB + TS_W;
  localparam int IN_IP_LSB   = IN_SENS_BIT + 1;
  localparam int IN_RAW_W    = IN_IP_LSB + IP_W;
  localparam int IN_W        = ((IN_RAW_W + 7) / 8) * 8;

  // out_tdata: fired, rule, verdict_pid, response tier, tracked, zero fill
  localparam int OUT_RAW_W = 1 + 2 + PID_W + 2 + 1;
  localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

  localparam logic [31:0] BURST_WINDOW_RST     = 32'd1000000;
  localparam logic [15:0] BURST_THRESHOLD_RST  = 16'd10;
  localparam logic [15:0] RECON_THRESHOLD_RST  = 16'd3;
  localparam logic [15:0] CANARY_THRESHOLD_RST = 16'd2;
  localparam logic [7:0]  RECON_INCREMENT_RST  = 8'd5;

  localparam logic [7:0] LOOPBACK_OCTET = 8'd127;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_NONE    = 3'd0,
    FUNC_READ    = 3'd1,
    FUNC_CANARY  = 3'd2,
    FUNC_CONNECT = 3'd3,
    FUNC_WRITE   = 3'd4,
    FUNC_RESET   = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    RULE_CANARY = 2'd0,
    RULE_EXFIL  = 2'd1,
    RULE_BURST  = 2'd2
  } rule_t;

  typedef enum logic [1:0] {
    TIER_NONE  = 2'd0,
    TIER_LOW   = 2'd1,
    TIER_HIGH  = 2'd2
  } tier_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BURST_WINDOW     = 3'd0,
    CFG_BURST_THRESHOLD  = 3'd1,
    CFG_RECON_THRESHOLD  = 3'd2,
    CFG_CANARY_THRESHOLD = 3'd3,
    CFG_RECON_INCREMENT  = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_MODIFY,
    S_OUT
  } state_t;

  typedef struct packed {
    logic en;
    logic claim;
  } cam_upd_t;

  typedef struct packed {
    logic hit;
    logic free_ok;
  } cam_stat_t;

endpackage

FILE: rtl/pert_cam.sv
// ----------------------------------------------------------------------------
// pert_cam
// Slot valid bits and pids with a parallel pid compare and lowest-free search.
// ----------------------------------------------------------------------------
module pert_cam #(
  parameter int SLOTS = 16,
  localparam int IDX_W = $clog2(SLOTS)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [pert_pkg::PID_W-1:0] lookup_pid,
  input  pert_pkg::cam_upd_t        upd,
  input  logic [IDX_W-1:0]          upd_idx,
  output pert_pkg::cam_stat_t       stat,
  output logic [IDX_W-1:0]          hit_idx,
  output logic [IDX_W-1:0]          free_idx
);
  import pert_pkg::*;

  logic [SLOTS-1:0] slot_valid_r;
  logic [PID_W-1:0] slot_pid_r [SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else if (upd.en) begin
      slot_valid_r[upd_idx] <= upd.claim;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en && upd.claim) begin
      slot_pid_r[upd_idx] <= lookup_pid;
    end
  end

  always_comb begin
    stat     = '0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_valid_r[i] && slot_pid_r[i] == lookup_pid) begin
        stat.hit = 1'b1;
        hit_idx  = IDX_W'(i);
      end
      if (!slot_valid_r[i]) begin
        stat.free_ok = 1'b1;
        free_idx     = IDX_W'(i);
      end
    end
  end

endmodule

FILE: rtl/pert_rec_mem.sv
// ----------------------------------------------------------------------------
// pert_rec_mem
// Record store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pert_rec_mem #(
  parameter int SLOTS = 16,
  parameter int WIDTH = 112,
  localparam int IDX_W = $clog2(SLOTS)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data
);
  import pert_pkg::*;

  logic [WIDTH-1:0] mem_r [SLOTS];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/per_process_event_rule_table.sv
// ----------------------------------------------------------------------------
// per_process_event_rule_table
// Per-process record table: finds or claims a record per event, updates its
// counters in a record memory and reports which rule, if any, fired.
//
//   channel  dir  handshake               payload
//   in_      in   in_tvalid/in_tready     in_tuser func, in_tdata event
//   out_     out  out_tvalid/out_tready   out_tdata verdict
//   cfg_     in   cfg_valid/cfg_ready     cfg_index, cfg_data
//
// Each word steps through pid compare and record read, modify and write
// back, result to the output register. One read-modify-write of the record
// memory is in flight at a time. Reset clears the slot valid bits at once;
// no clearing pass. A word is taken again once the previous result has
// moved into the output register; a stalled output holds the engine in its
// last step. Configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
module per_process_event_rule_table #(
  parameter int SLOTS         = 16,
  parameter int COUNTER_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [2:0] func
  input  logic [pert_pkg::FUNC_W-1:0]       in_tuser,
  // [31:0] pid, [95:32] timestamp, [96] sensitive_path, [128:97] dest_ip
  input  logic [pert_pkg::IN_W-1:0]         in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] fired, [2:1] rule, [34:3] verdict_pid, [36:35] tier,
  // [37] tracked
  output logic [pert_pkg::OUT_W-1:0]        out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pert_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pert_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pert_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CW    = COUNTER_WIDTH;
  localparam int REC_W = 3 * CW + TS_W;
  localparam int CMP_W = 32;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  state_t state_r, state_nxt;

  logic [31:0] burst_window_r;
  logic [15:0] burst_thr_r;
  logic [15:0] recon_thr_r;
  logic [15:0] canary_thr_r;
  logic [7:0]  recon_inc_r;

  logic [FUNC_W-1:0] func_r;
  logic [PID_W-1:0]  pid_r;
  logic [TS_W-1:0]   ts_r;
  logic              sens_r;
  logic [IP_W-1:0]   ip_r;

  logic             hit_r;
  logic             free_ok_r;
  logic [IDX_W-1:0] idx_r;

  logic [OUT_W-1:0] res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r;

  cam_upd_t         cam_upd;
  cam_stat_t        cam_stat;
  logic [IDX_W-1:0] hit_idx, free_idx, rd_addr;
  logic             in_acc, out_load, rd_en, wr_en;
  logic [REC_W-1:0] rd_data, rec_base, rec_new;

  logic pid_nz, is_reset, tracked, fired;
  rule_t rule;
  tier_t tier;

  logic [CW-1:0]   recon, canary, burst;
  logic [TS_W-1:0] lwt;
  logic [CW-1:0]   recon_n, canary_n, burst_n;
  logic [TS_W-1:0] lwt_n;
  logic [CW:0]     score_sum, canary_sum, burst_sum;
  logic [CW-1:0]   score_inc, canary_inc, burst_inc, burst_new;
  logic [TS_W-1:0] elapsed;
  logic            in_window;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_window_r <= BURST_WINDOW_RST;
      burst_thr_r    <= BURST_THRESHOLD_RST;
      recon_thr_r    <= RECON_THRESHOLD_RST;
      canary_thr_r   <= CANARY_THRESHOLD_RST;
      recon_inc_r    <= RECON_INCREMENT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BURST_WINDOW:     burst_window_r <= cfg_data;
        CFG_BURST_THRESHOLD:  burst_thr_r    <= cfg_data[15:0];
        CFG_RECON_THRESHOLD:  recon_thr_r    <= cfg_data[15:0];
        CFG_CANARY_THRESHOLD: canary_thr_r   <= cfg_data[15:0];
        CFG_RECON_INCREMENT:  recon_inc_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // capture word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_tuser;
      pid_r  <= in_tdata[IN_PID_LSB +: PID_W];
      ts_r   <= in_tdata[IN_TS_LSB +: TS_W];
      sens_r <= in_tdata[IN_SENS_BIT];
      ip_r   <= in_tdata[IN_IP_LSB +: IP_W];
    end
  end

  pert_cam #(.SLOTS(SLOTS)) u_cam (
    .clk        (clk),
    .rst_n      (rst_n),
    .lookup_pid (pid_r),
    .upd        (cam_upd),
    .upd_idx    (idx_r),
    .stat       (cam_stat),
    .hit_idx    (hit_idx),
    .free_idx   (free_idx)
  );

  assign rd_en   = (state_r == S_LOOKUP);
  assign rd_addr = cam_stat.hit ? hit_idx : free_idx;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      hit_r     <= cam_stat.hit;
      free_ok_r <= cam_stat.free_ok;
      idx_r     <= rd_addr;
    end
  end

  pert_rec_mem #(.SLOTS(SLOTS), .WIDTH(REC_W)) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (idx_r),
    .wr_data (rec_new)
  );

  // modify
  assign pid_nz   = (pid_r != '0);
  assign is_reset = (func_r == FUNC_RESET);
  assign tracked  = pid_nz && (is_reset ? hit_r : (hit_r || free_ok_r));

  assign cam_upd.en    = (state_r == S_MODIFY) && pid_nz &&
                         (is_reset ? hit_r : (!hit_r && free_ok_r));
  assign cam_upd.claim = !is_reset;
  assign wr_en         = (state_r == S_MODIFY) && tracked && !is_reset;

  assign rec_base = hit_r ? rd_data : '0;
  assign recon    = rec_base[0 +: CW];
  assign canary   = rec_base[CW +: CW];
  assign burst    = rec_base[2*CW +: CW];
  assign lwt      = rec_base[3*CW +: TS_W];

  assign score_sum  = {1'b0, recon} + (CW+1)'(recon_inc_r);
  assign score_inc  = score_sum[CW] ? CNT_MAX : score_sum[CW-1:0];
  assign canary_sum = {1'b0, canary} + (CW+1)'(1);
  assign canary_inc = canary_sum[CW] ? CNT_MAX : canary_sum[CW-1:0];
  assign burst_sum  = {1'b0, burst} + (CW+1)'(1);
  assign burst_inc  = burst_sum[CW] ? CNT_MAX : burst_sum[CW-1:0];
  assign elapsed    = ts_r - lwt;
  assign in_window  = (lwt != '0) && (elapsed < TS_W'(burst_window_r));
  assign burst_new  = in_window ? burst_inc : CW'(1);

  always_comb begin
    recon_n  = recon;
    canary_n = canary;
    burst_n  = burst;
    lwt_n    = lwt;
    fired    = 1'b0;
    rule     = RULE_CANARY;
    tier     = TIER_NONE;
    if (tracked && !is_reset) begin
      case (func_r)
        FUNC_READ: begin
          if (sens_r) recon_n = score_inc;
        end
        FUNC_CANARY: begin
          canary_n = canary_inc;
          if (CMP_W'(canary_inc) >= CMP_W'(canary_thr_r)) begin
            fired = 1'b1;
            rule  = RULE_CANARY;
            tier  = TIER_HIGH;
          end
        end
        FUNC_CONNECT: begin
          if (ip_r[7:0] != LOOPBACK_OCTET && CMP_W'(recon) > CMP_W'(recon_thr_r)) begin
            fired = 1'b1;
            rule  = RULE_EXFIL;
            tier  = TIER_HIGH;
          end
        end
        FUNC_WRITE: begin
          burst_n = burst_new;
          lwt_n   = ts_r;
          if (CMP_W'(burst_new) > CMP_W'(burst_thr_r)) begin
            fired = 1'b1;
            rule  = RULE_BURST;
            tier  = TIER_LOW;
          end
        end
        default: ;
      endcase
    end
    rec_new = {lwt_n, burst_n, canary_n, recon_n};
    res_nxt = OUT_W'({tracked, tier, (fired ? pid_r : {PID_W{1'b0}}), rule, fired});
  end

  always_ff @(posedge clk) begin
    if (state_r == S_MODIFY) begin
      res_r <= res_nxt;
    end
  end

  // sequencer
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_LOOKUP;
      S_LOOKUP: state_nxt = S_MODIFY;
      S_MODIFY: state_nxt = S_OUT;
      S_OUT:    if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_LOOKUP)
    else $error("accepted word did not start a lookup");

  a_claim_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (cam_upd.en && cam_upd.claim) |-> !hit_r)
    else $error("slot claimed for a pid that already has one");

  a_fired_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> (out_tdata[37] && out_tdata[34:3] != '0))
    else $error("verdict without a tracked record");

  a_reset_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MODIFY && is_reset) |-> !wr_en)
    else $error("record written on a pid reset");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Sends event words through the per-process event rule table and checks each
// verdict word against a predictor of the record table. A directed run hits
// the corner cases first. Random event streams follow under several register
// settings, with changing back-pressure on both sides of the block.
// ----------------------------------------------------------------------------
module testbench;
  import pert_pkg::*;

  localparam int SLOTS     = 16;
  localparam int CNT_W     = 16;
  localparam int POOL_N    = 22;
  localparam int SETTLE    = 8;
  localparam int RUN_LIMIT_NS = 10000000;
  localparam int O_RULE    = 1;
  localparam int O_PID     = 3;
  localparam int O_TIER    = 35;
  localparam int O_TRACKED = 37;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd7;

  typedef struct packed {
    logic        fired;
    logic [1:0]  rule;
    logic [31:0] vpid;
    logic [1:0]  tier;
    logic        tracked;
  } verdict_t;

  class verdict_scoreboard;
    logic             slot_used[SLOTS];
    logic [31:0]      slot_pid[SLOTS];
    logic [CNT_W-1:0] score[SLOTS];
    logic [CNT_W-1:0] canary[SLOTS];
    logic [CNT_W-1:0] burst[SLOTS];
    logic [63:0]      last_wr[SLOTS];
    logic [31:0]      window;
    logic [15:0]      burst_limit;
    logic [15:0]      recon_limit;
    logic [15:0]      canary_limit;
    logic [7:0]       recon_step;
    verdict_t         verdict_q[$];
    int               events;
    int               checked;
    int               mismatches;
    int               untracked;
    int               fires[3];

    function new();
      window       = BURST_WINDOW_RST;
      burst_limit  = BURST_THRESHOLD_RST;
      recon_limit  = RECON_THRESHOLD_RST;
      canary_limit = CANARY_THRESHOLD_RST;
      recon_step   = RECON_INCREMENT_RST;
      for (int i = 0; i < SLOTS; i++) begin
        slot_used[i] = 1'b0;
        clear_slot(i);
      end
      events = 0;
      checked = 0;
      mismatches = 0;
      untracked = 0;
      fires = '{0, 0, 0};
    endfunction

    function void clear_slot(int s);
      slot_pid[s] = '0;
      score[s]    = '0;
      canary[s]   = '0;
      burst[s]    = '0;
      last_wr[s]  = '0;
    endfunction

    function logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
      logic [CNT_W:0] sum;
      sum = a + b;
      return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] value);
      case (idx)
        CFG_BURST_WINDOW:     window       = value;
        CFG_BURST_THRESHOLD:  burst_limit  = value[15:0];
        CFG_RECON_THRESHOLD:  recon_limit  = value[15:0];
        CFG_CANARY_THRESHOLD: canary_limit = value[15:0];
        CFG_RECON_INCREMENT:  recon_step   = value[7:0];
        default: ;
      endcase
    endfunction

    function void note_event(logic [FUNC_W-1:0] f, logic [31:0] pid, logic [63:0] ts,
                             logic sens, logic [31:0] ip);
      verdict_t v;
      int s;
      v = '0;
      s = -1;
      if (pid != 0) begin
        for (int i = 0; i < SLOTS; i++)
          if (s < 0 && slot_used[i] && slot_pid[i] == pid) s = i;
        if (f == FUNC_RESET) begin
          if (s >= 0) begin
            slot_used[s] = 1'b0;
            clear_slot(s);
            v.tracked = 1'b1;
          end
        end else begin
          for (int i = 0; i < SLOTS; i++)
            if (s < 0 && !slot_used[i]) begin
              s = i;
              clear_slot(i);
              slot_pid[i]  = pid;
              slot_used[i] = 1'b1;
            end
          if (s >= 0) begin
            v.tracked = 1'b1;
            case (f)
              FUNC_READ: if (sens) score[s] = sat_add(score[s], {8'd0, recon_step});
              FUNC_CANARY: begin
                canary[s] = sat_add(canary[s], 16'd1);
                if (canary[s] >= canary_limit) begin
                  v.fired = 1'b1;
                  v.rule  = RULE_CANARY;
                  v.tier  = TIER_HIGH;
                end
              end
              FUNC_CONNECT: begin
                if (ip[7:0] != LOOPBACK_OCTET && score[s] > recon_limit) begin
                  v.fired = 1'b1;
                  v.rule  = RULE_EXFIL;
                  v.tier  = TIER_HIGH;
                end
              end
              FUNC_WRITE: begin
                if (last_wr[s] != 0 && (ts - last_wr[s]) < {32'd0, window})
                  burst[s] = sat_add(burst[s], 16'd1);
                else
                  burst[s] = 16'd1;
                last_wr[s] = ts;
                if (burst[s] > burst_limit) begin
                  v.fired = 1'b1;
                  v.rule  = RULE_BURST;
                  v.tier  = TIER_LOW;
                end
              end
              default: ;
            endcase
            if (v.fired) v.vpid = slot_pid[s];
          end
        end
      end
      events++;
      if (!v.tracked) untracked++;
      if (v.fired) fires[v.rule]++;
      verdict_q.push_back(v);
    endfunction

    function void check_verdict(logic [OUT_W-1:0] w);
      verdict_t got;
      verdict_t want;
      got.fired   = w[0];
      got.rule    = w[O_RULE +: 2];
      got.vpid    = w[O_PID +: PID_W];
      got.tier    = w[O_TIER +: 2];
      got.tracked = w[O_TRACKED];
      checked++;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: verdict word %h with none outstanding", w);
        return;
      end
      want = verdict_q.pop_front();
      if (got.fired !== want.fired || got.rule !== want.rule || got.vpid !== want.vpid ||
          got.tier !== want.tier || got.tracked !== want.tracked) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: verdict %0d: want fired %0d rule %0d pid %h tier %0d tracked %0d,",
                   checked, want.fired, want.rule, want.vpid, want.tier, want.tracked,
                   " got fired %0d rule %0d pid %h tier %0d tracked %0d",
                   got.fired, got.rule, got.vpid, got.tier, got.tracked);
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [FUNC_W-1:0]     in_tuser   = '0;
  logic [IN_W-1:0]       in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  verdict_scoreboard sb = new();
  int                send_idle  = 0;
  int                recv_idle  = 0;
  int                settings_n = 0;
  logic [31:0]       cur_window = BURST_WINDOW_RST;
  logic [63:0]       ts_clock   = 64'd5000;
  logic [31:0]       pid_pool[POOL_N];

  per_process_event_rule_table #(
    .SLOTS        (SLOTS),
    .COUNTER_WIDTH(CNT_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) sb.check_verdict(out_tdata);
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_event(input logic [FUNC_W-1:0] f, input logic [31:0] pid,
                            input logic [63:0] ts, input logic sens, input logic [31:0] ip);
    logic [IN_W-1:0] word;
    word = '0;
    word[IN_PID_LSB +: PID_W] = pid;
    word[IN_TS_LSB +: TS_W]   = ts;
    word[IN_SENS_BIT]         = sens;
    word[IN_IP_LSB +: IP_W]   = ip;
    if ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    sb.note_event(f, pid, ts, sens, ip);
  endtask

  task automatic wait_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [31:0] bw, input logic [15:0] bt,
                                input logic [15:0] rt, input logic [15:0] ct,
                                input logic [7:0] ri);
    cfg_idx_t    regs[5];
    logic [31:0] vals[5];
    regs = '{CFG_BURST_WINDOW, CFG_BURST_THRESHOLD, CFG_RECON_THRESHOLD,
             CFG_CANARY_THRESHOLD, CFG_RECON_INCREMENT};
    vals = '{bw, {16'd0, bt}, {16'd0, rt}, {16'd0, ct}, {24'd0, ri}};
    for (int k = 0; k < 5; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[k];
      cfg_data  <= vals[k];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(regs[k], vals[k]);
    end
    cfg_valid  <= 1'b0;
    cur_window = bw;
    settings_n++;
  endtask

  task automatic random_event();
    logic [FUNC_W-1:0] f;
    logic [31:0]       pid;
    logic [31:0]       ip;
    logic [63:0]       ts;
    logic [63:0]       span;
    int                r;
    r = $urandom_range(99);
    if (r < 22)      f = FUNC_READ;
    else if (r < 34) f = FUNC_CANARY;
    else if (r < 50) f = FUNC_CONNECT;
    else if (r < 75) f = FUNC_WRITE;
    else if (r < 85) f = FUNC_RESET;
    else if (r < 90) f = FUNC_NONE;
    else if (r < 95) f = FUNC_SPARE_A;
    else             f = FUNC_SPARE_B;
    r = $urandom_range(99);
    if (r < 4)       pid = '0;
    else if (r < 10) pid = $urandom;
    else             pid = pid_pool[$urandom_range(POOL_N - 1)];
    r = $urandom_range(99);
    span = {32'd0, cur_window} + {33'd0, cur_window[31:1]} + 64'd1;
    if (r < 3) begin
      ts = '0;
    end else if (r < 8) begin
      ts_clock = {$urandom, $urandom};
      ts = ts_clock;
    end else if (r < 12) begin
      ts = ts_clock - 64'($urandom_range(1000));
    end else begin
      ts_clock = ts_clock + ({32'd0, $urandom} % span);
      ts = ts_clock;
    end
    ip = $urandom;
    if ($urandom_range(99) < 25) ip[7:0] = LOOPBACK_OCTET;
    send_event(f, pid, ts, 1'($urandom_range(1)), ip);
  endtask

  task automatic run_random(input int count);
    repeat (count) random_event();
  endtask

  task automatic clear_table();
    logic [31:0] held[$];
    for (int i = 0; i < SLOTS; i++)
      if (sb.slot_used[i]) held.push_back(sb.slot_pid[i]);
    foreach (held[k]) send_event(FUNC_RESET, held[k], ts_clock, 1'b0, 32'd0);
  endtask

  initial begin
    #(RUN_LIMIT_NS);
    $display("ERROR: run did not complete in time");
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [31:0] pa;
    logic [31:0] pb;
    int          n;
    for (int i = 0; i < POOL_N; i++) begin
      pid_pool[i] = $urandom;
      if (pid_pool[i] == 0) pid_pool[i] = 32'd1;
    end
    pid_pool[0] = 32'd1;
    pid_pool[1] = 32'hFFFF_FFFF;
    pa = 32'h0000_1234;
    pb = 32'h8765_4321;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 24;
    recv_idle = 87;
    send_event(FUNC_READ, 32'd0, 64'd7, 1'b1, 32'd0);
    send_event(FUNC_WRITE, 32'd0, 64'd5, 1'b0, 32'd0);
    send_event(FUNC_NONE, pa, 64'd0, 1'b0, 32'd0);
    send_event(FUNC_SPARE_A, pb, 64'd0, 1'b0, 32'd0);
    send_event(FUNC_SPARE_B, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send_event(FUNC_READ, pa, 64'd0, 1'b1, 32'd0);
    send_event(FUNC_READ, pa, 64'd0, 1'b0, 32'd0);
    send_event(FUNC_CONNECT, pa, 64'd0, 1'b0, {24'h010000, LOOPBACK_OCTET});
    send_event(FUNC_CONNECT, pa, 64'd0, 1'b0, 32'hFFFF_FFFF);
    send_event(FUNC_CANARY, pb, 64'd0, 1'b0, 32'd0);
    send_event(FUNC_CANARY, pb, 64'd0, 1'b0, 32'd0);
    send_event(FUNC_WRITE, pa, 64'd0, 1'b0, 32'd0);
    send_event(FUNC_WRITE, pa, 64'd100, 1'b0, 32'd0);
    send_event(FUNC_WRITE, pa, 64'd200, 1'b0, 32'd0);
    send_event(FUNC_WRITE, pa, 64'd150, 1'b0, 32'd0);
    send_event(FUNC_WRITE, pa, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'd0);
    send_event(FUNC_CONNECT, pb, 64'd0, 1'b0, 32'h0A00_0001);
    send_event(FUNC_RESET, pa, 64'd0, 1'b0, 32'd0);
    send_event(FUNC_RESET, pa, 64'd0, 1'b0, 32'd0);
    send_event(FUNC_RESET, 32'd0, 64'd0, 1'b0, 32'd0);
    wait_results();

    apply_settings(32'd5000, 16'd3, 16'd10, 16'd3, 8'd4);
    run_random(35);
    wait_results();
    run_random(35);
    wait_results();

    send_idle = 87;
    recv_idle = 24;
    apply_settings(32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0, 8'd255);
    run_random(70);
    wait_results();

    send_idle = 0;
    recv_idle = 0;
    apply_settings(32'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd0);
    run_random(70);
    wait_results();

    apply_settings(32'd200000, 16'd4, 16'd20, 16'd5, 8'd9);
    run_random(70);
    clear_table();
    wait_results();

    // saturate one score, then check that it still clears a near-maximum threshold
    apply_settings(32'd1000000, 16'd10, 16'hFFFE, 16'd2, 8'd255);
    repeat (260) send_event(FUNC_READ, pa, ts_clock, 1'b1, $urandom);
    send_event(FUNC_CONNECT, pa, ts_clock, 1'b0, 32'h0A00_0001);
    send_event(FUNC_RESET, pa, ts_clock, 1'b0, 32'd0);
    in_tvalid <= 1'b0;

    for (n = 0; n < 5000 && sb.pending() != 0; n++) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.pending() != 0) $display("ERROR: %0d verdicts never arrived", sb.pending());
    $display("Sent %0d event words under %0d register settings; %0d verdicts checked.",
             sb.events, settings_n + 1, sb.checked);
    $display("Fired: canary %0d, exfil %0d, burst %0d; untracked events %0d.",
             sb.fires[RULE_CANARY], sb.fires[RULE_EXFIL], sb.fires[RULE_BURST], sb.untracked);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/pert_pkg.sv
rtl/pert_cam.sv
rtl/pert_rec_mem.sv
rtl/per_process_event_rule_table.sv
tb/testbench.sv
